/* rtl/infix_expression_evaluator_defines.svh */
// ----------------------------------------------------------------------------
// infix expression evaluator assertion macros
// shared concurrent check forms, clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define INFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// same-cycle implication
`define IEVAL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ieval: check failed");

// next-cycle implication
`define IEVAL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ieval: check failed");

`endif

/* rtl/ieval_pkg.sv */
// ----------------------------------------------------------------------------
// ieval_pkg
// types, character codes and operator decode for the infix expression evaluator
// ----------------------------------------------------------------------------
package ieval_pkg;

  localparam int RESULT_WIDTH = 32;

  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_TIMES  = 8'h2A;
  localparam logic [7:0] CHAR_DIVIDE = 8'h2F;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  typedef enum logic [2:0] {
    OP_PLUS   = 3'd0,
    OP_MINUS  = 3'd1,
    OP_TIMES  = 3'd2,
    OP_DIVIDE = 3'd3,
    OP_OTHER  = 3'd4
  } op_code_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ARITH,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_mark;
  } in_item_t;

  typedef struct packed {
    logic signed [RESULT_WIDTH-1:0] value;
    logic                           divide_error;
  } result_t;

  typedef struct packed {
    op_code_t op;
    logic     last;
  } cmd_ctrl_t;

  typedef struct packed {
    logic start;
    logic divide;
  } arith_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_stat_t;

  function automatic op_code_t op_decode(input logic [7:0] c);
    op_code_t op;
    case (c)
      CHAR_PLUS:   op = OP_PLUS;
      CHAR_MINUS:  op = OP_MINUS;
      CHAR_TIMES:  op = OP_TIMES;
      CHAR_DIVIDE: op = OP_DIVIDE;
      default:     op = OP_OTHER;
    endcase
    return op;
  endfunction

endpackage

/* rtl/infix_expression_evaluator.sv */
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// streaming + - * / evaluator over ascii text, one character per request
// ----------------------------------------------------------------------------
// Input channel: push/full with item (char_code, end_mark). A character is
// taken on every cycle that full is low; full rises only when the command
// queue between front and back is full.
// Result channel: empty/pop with result (value, divide_error). One result
// per expression, produced by the character that carries end_mark.
// The front takes one character per cycle while full is low. Each
// operator, unknown character or end mark becomes a command for the
// back: plus, minus, unknown characters and divide by zero need no
// arithmetic; a multiply holds the back in the shift-add multiplier,
// one step per multiplier bit up to the highest set bit; a divide holds
// it for VALUE_WIDTH steps in the restoring divider.
// Reset (rst, synchronous) clears the operand, the queue, sum, term and
// error flag, and empties the result register. A stalled receiver holds
// the back at its emit step; the queue then fills and full rises.
// ----------------------------------------------------------------------------
module infix_expression_evaluator #(
  parameter int VALUE_WIDTH = 32,
  parameter int CMD_DEPTH   = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  ieval_pkg::in_item_t  item,
  output logic                 empty,
  input  logic                 pop,
  output ieval_pkg::result_t   result
);

  localparam int CMD_WIDTH = $bits(ieval_pkg::cmd_ctrl_t) + VALUE_WIDTH;

  logic                   front_push;
  ieval_pkg::cmd_ctrl_t   front_ctrl;
  logic [VALUE_WIDTH-1:0] front_operand;
  logic [CMD_WIDTH-1:0]   queue_out;
  logic                   queue_full;
  logic                   queue_empty;
  logic                   back_pop;
  ieval_pkg::cmd_ctrl_t   back_ctrl;
  logic [VALUE_WIDTH-1:0] back_operand;
  ieval_pkg::arith_ctrl_t arith_ctrl;
  ieval_pkg::arith_stat_t arith_stat;
  logic [VALUE_WIDTH-1:0] arith_a;
  logic [VALUE_WIDTH-1:0] arith_b;
  logic [VALUE_WIDTH-1:0] arith_result;

  assign full = queue_full;

  ieval_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .item        (item),
    .cmd_full    (queue_full),
    .cmd_push    (front_push),
    .cmd_ctrl    (front_ctrl),
    .cmd_operand (front_operand)
  );

  ieval_cmd_fifo #(
    .WIDTH(CMD_WIDTH),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_data ({front_ctrl, front_operand}),
    .full      (queue_full),
    .pop       (back_pop),
    .pop_data  (queue_out),
    .empty     (queue_empty)
  );

  assign {back_ctrl, back_operand} = queue_out;

  ieval_arith #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_arith (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (arith_ctrl),
    .operand_a (arith_a),
    .operand_b (arith_b),
    .stat      (arith_stat),
    .product   (arith_result)
  );

  ieval_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (!queue_empty),
    .cmd_ctrl     (back_ctrl),
    .cmd_operand  (back_operand),
    .cmd_pop      (back_pop),
    .arith_ctrl   (arith_ctrl),
    .arith_a      (arith_a),
    .arith_b      (arith_b),
    .arith_stat   (arith_stat),
    .arith_result (arith_result),
    .empty        (empty),
    .pop          (pop),
    .result       (result)
  );

endmodule

/* rtl/ieval_front.sv */
// ----------------------------------------------------------------------------
// ieval_front
// accepts characters, builds the decimal operand and issues commit commands
// ----------------------------------------------------------------------------
module ieval_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  ieval_pkg::in_item_t      item,
  input  logic                     cmd_full,
  output logic                     cmd_push,
  output ieval_pkg::cmd_ctrl_t     cmd_ctrl,
  output logic [VALUE_WIDTH-1:0]   cmd_operand
);

  logic [VALUE_WIDTH-1:0] operand_accum, operand_accum_next;
  ieval_pkg::op_code_t    pending_op, pending_op_next;
  logic [VALUE_WIDTH-1:0] operand_shifted;
  logic [3:0]             digit_value;
  logic                   accept;
  logic                   is_digit;
  logic                   is_space;
  logic                   commit;

  assign accept      = push && !cmd_full;
  assign is_digit    = item.char_code inside {[ieval_pkg::CHAR_ZERO:ieval_pkg::CHAR_NINE]};
  assign is_space    = (item.char_code == ieval_pkg::CHAR_SPACE);
  assign digit_value = 4'(item.char_code - ieval_pkg::CHAR_ZERO);

  // times ten plus digit, wrapping
  assign operand_shifted = (operand_accum << 3) + (operand_accum << 1)
                         + VALUE_WIDTH'(digit_value);

  assign commit = accept && ((!is_digit && !is_space) || item.end_mark);

  always_comb begin
    operand_accum_next = operand_accum;
    pending_op_next    = pending_op;
    if (commit) begin
      operand_accum_next = '0;
      pending_op_next    = item.end_mark ? ieval_pkg::OP_PLUS
                                         : ieval_pkg::op_decode(item.char_code);
    end else if (accept && is_digit) begin
      operand_accum_next = operand_shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      operand_accum <= '0;
      pending_op    <= ieval_pkg::OP_PLUS;
    end else begin
      operand_accum <= operand_accum_next;
      pending_op    <= pending_op_next;
    end
  end

  assign cmd_push      = commit;
  assign cmd_ctrl.op   = pending_op;
  assign cmd_ctrl.last = item.end_mark;
  assign cmd_operand   = is_digit ? operand_shifted : operand_accum;

endmodule

/* rtl/ieval_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// ieval_cmd_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module ieval_cmd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign pop_data = entries[rd_ptr];

endmodule

/* rtl/ieval_arith.sv */
// ----------------------------------------------------------------------------
// ieval_arith
// iterative shift-add multiplier and restoring signed divider
// ----------------------------------------------------------------------------
module ieval_arith #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ieval_pkg::arith_ctrl_t     ctrl,
  input  logic [VALUE_WIDTH-1:0]     operand_a,
  input  logic [VALUE_WIDTH-1:0]     operand_b,
  output ieval_pkg::arith_stat_t     stat,
  output logic [VALUE_WIDTH-1:0]     product
);

  localparam int STEP_W = $clog2(VALUE_WIDTH + 1);

  logic                   busy;
  logic                   divide_mode;
  logic                   negate;
  logic [VALUE_WIDTH-1:0] work_a;
  logic [VALUE_WIDTH-1:0] work_b;
  logic [VALUE_WIDTH-1:0] accum;
  logic [STEP_W-1:0]      steps_left;
  logic [VALUE_WIDTH-1:0] mag_a, mag_b;
  logic [VALUE_WIDTH:0]   trial;
  logic                   done;

  assign mag_a = operand_a[VALUE_WIDTH-1] ? (~operand_a + 1'b1) : operand_a;
  assign mag_b = operand_b[VALUE_WIDTH-1] ? (~operand_b + 1'b1) : operand_b;
  assign trial = {accum, work_a[VALUE_WIDTH-1]} - {1'b0, work_b};
  assign done  = busy && (divide_mode ? (steps_left == '0) : (work_b == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      divide_mode <= ctrl.divide;
      negate      <= operand_a[VALUE_WIDTH-1] ^ operand_b[VALUE_WIDTH-1];
      accum       <= '0;
      steps_left  <= STEP_W'(VALUE_WIDTH);
      work_a      <= ctrl.divide ? mag_a : operand_a;
      work_b      <= ctrl.divide ? mag_b : operand_b;
    end else if (busy && !done) begin
      if (divide_mode) begin
        if (!trial[VALUE_WIDTH]) begin
          accum  <= trial[VALUE_WIDTH-1:0];
          work_a <= {work_a[VALUE_WIDTH-2:0], 1'b1};
        end else begin
          accum  <= {accum[VALUE_WIDTH-2:0], work_a[VALUE_WIDTH-1]};
          work_a <= {work_a[VALUE_WIDTH-2:0], 1'b0};
        end
        steps_left <= steps_left - 1'b1;
      end else begin
        if (work_b[0]) begin
          accum <= accum + work_a;
        end
        work_a <= work_a << 1;
        work_b <= work_b >> 1;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign product   = divide_mode ? (negate ? (~work_a + 1'b1) : work_a) : accum;

endmodule

/* rtl/ieval_back.sv */
// ----------------------------------------------------------------------------
// ieval_back
// executes commit commands on sum and term and holds the result register
// ----------------------------------------------------------------------------
`include "infix_expression_evaluator_defines.svh"

module ieval_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  input  ieval_pkg::cmd_ctrl_t       cmd_ctrl,
  input  logic [VALUE_WIDTH-1:0]     cmd_operand,
  output logic                       cmd_pop,
  output ieval_pkg::arith_ctrl_t     arith_ctrl,
  output logic [VALUE_WIDTH-1:0]     arith_a,
  output logic [VALUE_WIDTH-1:0]     arith_b,
  input  ieval_pkg::arith_stat_t     arith_stat,
  input  logic [VALUE_WIDTH-1:0]     arith_result,
  output logic                       empty,
  input  logic                       pop,
  output ieval_pkg::result_t         result
);

  ieval_pkg::back_state_t state, state_next;

  logic [VALUE_WIDTH-1:0]             running_sum;
  logic [VALUE_WIDTH-1:0]             current_term;
  logic                               error_seen;
  logic                               last_pending;
  logic                               out_valid;
  logic [ieval_pkg::RESULT_WIDTH-1:0] out_value;
  logic                               out_error;
  logic                               needs_arith;
  logic                               out_free;
  logic                               out_load;
  logic [VALUE_WIDTH-1:0]             total;
  logic [63:0]                        total_wide;

  assign needs_arith = (cmd_ctrl.op == ieval_pkg::OP_TIMES)
                    || ((cmd_ctrl.op == ieval_pkg::OP_DIVIDE) && (cmd_operand != '0));
  assign out_free    = !out_valid || pop;
  assign total       = running_sum + current_term;
  assign total_wide  = 64'(total);

  always_comb begin
    state_next = state;
    case (state)
      ieval_pkg::BK_IDLE: begin
        if (cmd_valid) begin
          if (needs_arith) begin
            state_next = ieval_pkg::BK_ARITH;
          end else if (cmd_ctrl.last) begin
            state_next = ieval_pkg::BK_EMIT;
          end
        end
      end
      ieval_pkg::BK_ARITH: begin
        if (arith_stat.done) begin
          state_next = last_pending ? ieval_pkg::BK_EMIT : ieval_pkg::BK_IDLE;
        end
      end
      ieval_pkg::BK_EMIT: begin
        if (out_free) begin
          state_next = ieval_pkg::BK_IDLE;
        end
      end
      default: state_next = ieval_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop           = (state == ieval_pkg::BK_IDLE) && cmd_valid;
    arith_ctrl.start  = cmd_pop && needs_arith;
    arith_ctrl.divide = (cmd_ctrl.op == ieval_pkg::OP_DIVIDE);
    out_load          = (state == ieval_pkg::BK_EMIT) && out_free;
  end

  // term is the dividend and multiplicand, the operand the divisor and multiplier
  assign arith_a = current_term;
  assign arith_b = cmd_operand;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ieval_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      current_term <= '0;
      error_seen   <= 1'b0;
      last_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd_pop) begin
        last_pending <= cmd_ctrl.last;
        case (cmd_ctrl.op)
          ieval_pkg::OP_PLUS: begin
            running_sum  <= total;
            current_term <= cmd_operand;
          end
          ieval_pkg::OP_MINUS: begin
            running_sum  <= total;
            current_term <= ~cmd_operand + 1'b1;
          end
          ieval_pkg::OP_DIVIDE: begin
            if (cmd_operand == '0) begin
              current_term <= '0;
              error_seen   <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      if ((state == ieval_pkg::BK_ARITH) && arith_stat.done) begin
        current_term <= arith_result;
      end
      if (out_load) begin
        running_sum  <= '0;
        current_term <= '0;
        error_seen   <= 1'b0;
        out_valid    <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value <= total_wide[ieval_pkg::RESULT_WIDTH-1:0];
      out_error <= error_seen;
    end
  end

  assign empty               = !out_valid;
  assign result.value        = signed'(out_value);
  assign result.divide_error = out_error;

  `IEVAL_ASSERT_IMP(a_start_when_free, arith_ctrl.start, !arith_stat.busy)
  `IEVAL_ASSERT_IMP(a_arith_running, state == ieval_pkg::BK_ARITH, arith_stat.busy)
  `IEVAL_ASSERT_NEXT(a_result_held, out_valid && !pop, out_valid && $stable(out_value))
  `IEVAL_ASSERT_NEXT(a_cleared_after_emit, out_load,
                     running_sum == '0 && current_term == '0 && !error_seen)

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// infix expression evaluator testbench
// streams ascii expressions through the push/full side and checks every
// result popped from the empty/pop side against a cycle-free software
// evaluator kept in step with each accepted request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int          RESULT_WIDTH = ieval_pkg::RESULT_WIDTH;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          DRAIN_CYCLES = 2 * RESULT_WIDTH + 16;
  localparam logic [31:0] DECIMAL_BASE = 32'd10;

  logic                clk = 1'b0;
  logic                rst;
  logic                push;
  logic                full;
  ieval_pkg::in_item_t item;
  logic                empty;
  logic                pop;
  ieval_pkg::result_t  result;

  // software evaluator state
  logic [RESULT_WIDTH-1:0] eval_operand;
  ieval_pkg::op_code_t     eval_op;
  logic [RESULT_WIDTH-1:0] eval_sum;
  logic [RESULT_WIDTH-1:0] eval_term;
  logic                    eval_div_err;

  ieval_pkg::result_t awaited_results[$];
  ieval_pkg::result_t oldest_result;

  int send_idle_pct;
  int recv_idle_pct;
  int requests_sent;
  int results_checked;
  int div_error_results;
  int mismatches;
  int cycle_count;

  infix_expression_evaluator uut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void clear_evaluator();
    eval_operand = '0;
    eval_op      = ieval_pkg::OP_PLUS;
    eval_sum     = '0;
    eval_term    = '0;
    eval_div_err = 1'b0;
  endfunction

  // advance the evaluator by one accepted character
  function automatic void evaluate_char(input ieval_pkg::in_item_t req);
    logic                    is_digit;
    logic [RESULT_WIDTH-1:0] mag_a;
    logic [RESULT_WIDTH-1:0] mag_b;
    logic [RESULT_WIDTH-1:0] quo;
    ieval_pkg::result_t      res;
    is_digit = (req.char_code >= ieval_pkg::CHAR_ZERO)
            && (req.char_code <= ieval_pkg::CHAR_NINE);
    if (is_digit) begin
      eval_operand = eval_operand * DECIMAL_BASE
                   + RESULT_WIDTH'(req.char_code - ieval_pkg::CHAR_ZERO);
    end
    if ((!is_digit && req.char_code != ieval_pkg::CHAR_SPACE) || req.end_mark) begin
      case (eval_op)
        ieval_pkg::OP_PLUS: begin
          eval_sum  = eval_sum + eval_term;
          eval_term = eval_operand;
        end
        ieval_pkg::OP_MINUS: begin
          eval_sum  = eval_sum + eval_term;
          eval_term = -eval_operand;
        end
        ieval_pkg::OP_TIMES: begin
          eval_term = eval_term * eval_operand;
        end
        ieval_pkg::OP_DIVIDE: begin
          if (eval_operand == '0) begin
            eval_term    = '0;
            eval_div_err = 1'b1;
          end else begin
            mag_a     = eval_term[RESULT_WIDTH-1] ? -eval_term : eval_term;
            mag_b     = eval_operand[RESULT_WIDTH-1] ? -eval_operand : eval_operand;
            quo       = mag_a / mag_b;
            eval_term = (eval_term[RESULT_WIDTH-1] ^ eval_operand[RESULT_WIDTH-1]) ? -quo : quo;
          end
        end
        default: begin
        end
      endcase
      eval_operand = '0;
      case (req.char_code)
        ieval_pkg::CHAR_PLUS:   eval_op = ieval_pkg::OP_PLUS;
        ieval_pkg::CHAR_MINUS:  eval_op = ieval_pkg::OP_MINUS;
        ieval_pkg::CHAR_TIMES:  eval_op = ieval_pkg::OP_TIMES;
        ieval_pkg::CHAR_DIVIDE: eval_op = ieval_pkg::OP_DIVIDE;
        default:                eval_op = ieval_pkg::OP_OTHER;
      endcase
    end
    if (req.end_mark) begin
      res.value        = eval_sum + eval_term;
      res.divide_error = eval_div_err;
      awaited_results  = {awaited_results, res};
      clear_evaluator();
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (awaited_results.size() == 0) begin
        $error("result with none expected: value %0d", result.value);
        mismatches++;
      end else begin
        oldest_result = awaited_results.pop_front();
        results_checked++;
        if (oldest_result.divide_error) begin
          div_error_results++;
        end
        if (result.value !== oldest_result.value) begin
          $error("value mismatch: expected %0d, got %0d", oldest_result.value, result.value);
          mismatches++;
        end
        if (result.divide_error !== oldest_result.divide_error) begin
          $error("divide_error mismatch: expected %0b, got %0b",
                 oldest_result.divide_error, result.divide_error);
          mismatches++;
        end
      end
    end
  end

  // receiver
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      pop <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_request(input logic [7:0] code, input logic last);
    ieval_pkg::in_item_t req;
    req.char_code = code;
    req.end_mark  = last;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      push <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    push <= 1'b1;
    item <= req;
    do @(posedge clk); while (full);
    evaluate_char(req);
    if (code != ieval_pkg::CHAR_SPACE) begin
      requests_sent++;
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_request(s[i], i == s.len() - 1);
    end
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    push <= 1'b0;
    while (awaited_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [7:0] random_operator();
    logic [7:0] c;
    case ($urandom_range(3))
      0:       c = ieval_pkg::CHAR_PLUS;
      1:       c = ieval_pkg::CHAR_MINUS;
      2:       c = ieval_pkg::CHAR_TIMES;
      default: c = ieval_pkg::CHAR_DIVIDE;
    endcase
    return c;
  endfunction

  // most negative value divided by minus one, divide by zero after a
  // leading divide, end mark on an unknown high byte
  task automatic test_division_extremes();
    send_text("-2147483648/4294967295");
    send_request(ieval_pkg::CHAR_DIVIDE, 1'b0);
    send_request(ieval_pkg::CHAR_ZERO, 1'b0);
    send_request(8'hFF, 1'b1);
  endtask

  // unknown character drops the next operand, end mark on a space
  task automatic test_unknown_chars();
    send_request(8'h00, 1'b0);
    send_text("7* ");
  endtask

  // leading times, end mark on an operator
  task automatic test_leading_operator();
    send_text("*7+");
  endtask

  task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
    logic [7:0] text[$];
    int         first;
    int         n_terms;
    int         n_digits;
    int         pick;
    logic       paused;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    first         = requests_sent;
    paused        = 1'b0;
    while (requests_sent - first < n_items) begin
      if (!paused && requests_sent - first >= n_items / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
      text.delete();
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 6)) begin
          send_request(8'($urandom_range(255)), $urandom_range(4) == 0);
        end
      end else begin
        n_terms = $urandom_range(1, 5);
        if ($urandom_range(9) == 0) begin
          text = {text, random_operator()};
        end
        for (int t = 0; t < n_terms; t++) begin
          if (t > 0) begin
            text = {text, random_operator()};
          end
          if ($urandom_range(5) == 0) begin
            text = {text, ieval_pkg::CHAR_SPACE};
          end
          pick = $urandom_range(99);
          if (pick < 70) begin
            n_digits = $urandom_range(1, 3);
          end else if (pick < 80) begin
            n_digits = 0;
          end else if (pick < 93) begin
            n_digits = $urandom_range(4, 9);
          end else begin
            n_digits = $urandom_range(10, 12);
          end
          repeat (n_digits) begin
            text = {text, 8'(ieval_pkg::CHAR_ZERO + 8'($urandom_range(9)))};
          end
          if ($urandom_range(5) == 0) begin
            text = {text, ieval_pkg::CHAR_SPACE};
          end
        end
        if ($urandom_range(3) == 0) begin
          text = {text, ($urandom_range(1) ? ieval_pkg::CHAR_SPACE : random_operator())};
        end
        if (text.size() == 0) begin
          text = {text, ieval_pkg::CHAR_SPACE};
        end
        foreach (text[i]) begin
          send_request(($urandom_range(99) < 3) ? 8'($urandom_range(255)) : text[i],
                       i == text.size() - 1);
        end
      end
    end
  endtask

  initial begin
    rst               = 1'b1;
    push              = 1'b0;
    item              = '0;
    send_idle_pct     = 32;
    recv_idle_pct     = 47;
    requests_sent     = 0;
    results_checked   = 0;
    div_error_results = 0;
    mismatches        = 0;
    cycle_count       = 0;
    clear_evaluator();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_division_extremes();
    test_unknown_chars();
    test_leading_operator();
    test_random_traffic(700, 32, 47);
    test_random_traffic(700, 47, 32);
    test_random_traffic(600, 0, 0);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d non-space characters, checked %0d expression results",
             requests_sent, results_checked);
    $display("%0d results flagged divide by zero, %0d mismatches",
             div_error_results, mismatches);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* infix_expression_evaluator.f */
+incdir+rtl
rtl/ieval_pkg.sv
rtl/ieval_front.sv
rtl/ieval_cmd_fifo.sv
rtl/ieval_arith.sv
rtl/ieval_back.sv
rtl/infix_expression_evaluator.sv
verif/testbench.sv
